### rtl/drsu_pkg.sv
// Package for the delta-rule state update: payload types, states, constants, sigmoid table, 32-bit saturation.
package drsu_pkg;
	localparam int HeadDimMax = 64;
	localparam int NumHeads   = 16;
	localparam int IdxW       = $clog2(HeadDimMax);
	localparam int HeadW      = $clog2(NumHeads);
	localparam int MemDepth   = NumHeads * HeadDimMax * HeadDimMax;
	localparam int AddrW      = HeadW + 2 * IdxW;

	typedef struct packed {
		logic [HeadW-1:0]   head;
		logic signed [15:0] q_value;
		logic signed [15:0] k_value;
		logic signed [15:0] v_value;
		logic               last_element;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] ctx_value;
		logic [HeadW-1:0]   out_head;
		logic [IdxW-1:0]    out_index;
		logic               last_result;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SIG, ST_A_RD, ST_A_MAC, ST_A_END, ST_U_BD, ST_U_MUL1, ST_U_MUL2,
		ST_U_RD, ST_U_MAC, ST_U_WR, ST_C_RD, ST_C_MAC, ST_C_END, ST_C_OUT
	} state_t;

	function automatic logic [15:0] sig_tab(input logic [4:0] e);
		logic [15:0] r;
		case (e)
			5'd0:  r = 16'd32768;
			5'd1:  r = 16'd40793;
			5'd2:  r = 16'd47911;
			5'd3:  r = 16'd53581;
			5'd4:  r = 16'd57724;
			5'd5:  r = 16'd60565;
			5'd6:  r = 16'd62428;
			5'd7:  r = 16'd63615;
			5'd8:  r = 16'd64357;
			5'd9:  r = 16'd64816;
			5'd10: r = 16'd65097;
			5'd11: r = 16'd65269;
			5'd12: r = 16'd65374;
			5'd13: r = 16'd65438;
			5'd14: r = 16'd65476;
			5'd15: r = 16'd65500;
			default: r = 16'd65514;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) r = 32'sh7fffffff;
		else if (x < -64'sd2147483648) r = 32'sh80000000;
		else r = x[31:0];
		return r;
	endfunction
endpackage

### rtl/delta_rule_state_update.sv
// Delta-rule linear-attention state update: top level with sequencer and shared MAC.
// Loading: one item per cycle while busy is low; busy stays low until an item with last_element is taken.
// Update: after the last item the block runs its passes over the state memory, busy meanwhile,
// and every product of every pass goes through the one shared 32x33 multiplier.
// Results come one per output index during the last pass and cannot be stalled.
// Reset: after arst_n the block sweeps the state memory to zero, 65536 cycles with busy high.
module delta_rule_state_update (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  drsu_pkg::in_item_t   in_item,
	input  logic                 cfg_we,
	input  logic [6:0]           cfg_data,
	output logic                 result_valid,
	output drsu_pkg::out_item_t  result
);
	import drsu_pkg::*;

	logic signed [31:0] smem [MemDepth];
	logic signed [15:0] qbuf [HeadDimMax];
	logic signed [15:0] kbuf [HeadDimMax];
	logic signed [15:0] vbuf [HeadDimMax];
	logic signed [31:0] abuf [HeadDimMax];

	state_t state_q, state_d;
	logic [6:0] head_dim_q, hd_q;
	logic [6:0] load_q;
	logic clr_q;
	logic [AddrW-1:0] clr_addr_q;
	logic [HeadW-1:0] head_q;
	logic [IdxW-1:0] i_q, j_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] rd_q;
	logic signed [16:0] beta_q;
	logic signed [31:0] bd_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] wr_q;
	logic signed [15:0] k0_q;
	logic signed [15:0] k_rd_q, q_rd_q, v_rd_q;
	logic signed [31:0] a_rd_q;
	out_item_t res_q;
	logic res_v_q;

	logic accept;
	logic [AddrW-1:0] addr;
	logic signed [31:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [63:0] mul_p;
	logic [IdxW-1:0] hd_last;
	logic [15:0] kabs;
	logic [15:0] y;
	logic [15:0] tdiff;
	logic [26:0] fr;
	logic signed [63:0] rnd12, rnd16, sum;

	assign accept = start && !busy;
	assign hd_last = IdxW'(hd_q - 7'd1);
	assign addr = {head_q, i_q, j_q};
	assign mul_p = 64'(mul_a) * 64'(mul_b);
	assign rnd12 = (acc_q + 64'sd2048) >>> 12;

	// sigmoid of k[0]
	always_comb begin
		kabs = k0_q[15] ? 16'(-k0_q) : k0_q;
		tdiff = sig_tab(5'(kabs[15:11]) + 5'd1) - sig_tab(5'(kabs[15:11]));
		fr = 27'(tdiff) * 27'(kabs[10:0]) + 27'd1024;
		if (kabs[15]) y = sig_tab(5'd16);
		else y = sig_tab(5'(kabs[15:11])) + 16'(fr >> 11);
	end

	always_comb begin
		mul_a = rd_q;
		mul_b = 33'(k_rd_q);
		case (state_q)
			ST_C_MAC:  mul_b = 33'(q_rd_q);
			ST_U_MUL1: begin
				mul_a = 32'(beta_q);
				mul_b = 33'(32'($signed({v_rd_q, 4'b0}))) - 33'(a_rd_q);
			end
			ST_U_MUL2: begin
				mul_a = bd_q;
				mul_b = 33'(k_rd_q);
			end
			default: ;
		endcase
	end

	assign rnd16 = (prod_q + 64'sd32768) >>> 16;
	assign sum = 64'(rd_q) + ((prod_q + 64'sd2048) >>> 12);

	always_comb begin
		state_d = state_q;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = clr_q;
				if (accept && in_item.last_element && in_item.head < HeadW'(NumHeads - 1) + 1)
					state_d = ST_SIG;
			end
			ST_SIG:    state_d = ST_A_RD;
			ST_A_RD:   state_d = ST_A_MAC;
			ST_A_MAC:  state_d = (i_q == hd_last) ? ST_A_END : ST_A_RD;
			ST_A_END:  state_d = (j_q == hd_last) ? ST_U_BD : ST_A_RD;
			ST_U_BD:   state_d = ST_U_MUL1;
			ST_U_MUL1: state_d = ST_U_RD;
			ST_U_RD:   state_d = ST_U_MUL2;
			ST_U_MUL2: state_d = ST_U_MAC;
			ST_U_MAC:  state_d = ST_U_WR;
			ST_U_WR: begin
				if (i_q != hd_last) state_d = ST_U_RD;
				else if (j_q == hd_last) state_d = ST_C_RD;
				else state_d = ST_U_BD;
			end
			ST_C_RD:   state_d = ST_C_MAC;
			ST_C_MAC:  state_d = (i_q == hd_last) ? ST_C_END : ST_C_RD;
			ST_C_END:  state_d = ST_C_OUT;
			ST_C_OUT:  state_d = (j_q == hd_last) ? ST_IDLE : ST_C_RD;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_dim_q <= 7'(HeadDimMax);
			load_q <= '0;
			clr_q <= 1'b1;
			clr_addr_q <= '0;
			res_v_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
		end else begin
			state_q <= state_d;
			res_v_q <= (state_q == ST_C_END);
			if (cfg_we) head_dim_q <= cfg_data;
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (&clr_addr_q) clr_q <= 1'b0;
			end
			if (accept) begin
				if (in_item.last_element) load_q <= '0;
				else if (load_q < 7'(HeadDimMax)) load_q <= load_q + 7'd1;
			end
			case (state_q)
				ST_IDLE: begin
					i_q <= '0;
					j_q <= '0;
				end
				ST_A_MAC, ST_C_MAC, ST_U_WR: i_q <= (i_q == hd_last) ? '0 : i_q + 1'b1;
				default: ;
			endcase
			if ((state_q == ST_A_END || state_q == ST_C_OUT
					|| (state_q == ST_U_WR && i_q == hd_last)))
				j_q <= (j_q == hd_last) ? '0 : j_q + 1'b1;
		end
	end

	// datapath, payload only
	always_ff @(posedge clk) begin
		if (accept && load_q < 7'(HeadDimMax)) begin
			qbuf[load_q[IdxW-1:0]] <= in_item.q_value;
			kbuf[load_q[IdxW-1:0]] <= in_item.k_value;
			vbuf[load_q[IdxW-1:0]] <= in_item.v_value;
			if (load_q == 7'd0) k0_q <= in_item.k_value;
		end
		if (accept && in_item.last_element) begin
			head_q <= in_item.head;
			if (head_dim_q == 7'd0) hd_q <= 7'd1;
			else if (head_dim_q > 7'(HeadDimMax)) hd_q <= 7'(HeadDimMax);
			else hd_q <= head_dim_q;
		end
		if (clr_q) smem[clr_addr_q] <= '0;
		else if (state_q == ST_U_WR) smem[addr] <= wr_q;
		rd_q <= smem[addr];
		// buffer reads are registered ahead of the MAC state that uses them
		k_rd_q <= kbuf[i_q];
		q_rd_q <= qbuf[i_q];
		v_rd_q <= vbuf[j_q];
		a_rd_q <= abuf[j_q];
		case (state_q)
			ST_SIG: begin
				beta_q <= k0_q[15] ? 17'(17'd65536 - 17'(y)) : 17'(y);
				acc_q <= '0;
			end
			ST_A_MAC, ST_C_MAC: acc_q <= acc_q + mul_p;
			ST_A_END: begin
				abuf[j_q] <= sat32(rnd12);
				acc_q <= '0;
			end
			ST_U_MUL1, ST_U_MUL2: prod_q <= mul_p;
			ST_U_MAC: wr_q <= sat32(sum);
			ST_U_RD: if (i_q == '0) bd_q <= 32'(rnd16);
			ST_U_WR: acc_q <= '0;
			ST_C_END: begin
				res_q.ctx_value <= sat32(rnd12);
				res_q.out_head <= head_q;
				res_q.out_index <= j_q;
				res_q.last_result <= (j_q == hd_last);
			end
			ST_C_OUT: acc_q <= '0;
			default: ;
		endcase
	end

	assign result_valid = res_v_q;
	assign result = res_q;

	property p_no_accept_while_busy;
		@(posedge clk) disable iff (!arst_n) (state_q != ST_IDLE) |-> busy;
	endproperty
	a_busy: assert property (p_no_accept_while_busy) else $error("busy low outside idle");

	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q) == ST_C_END) else $error("stray result");

	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> state_q == ST_IDLE) else $error("work during clearing");
endmodule
